// ===== src/gmbrt_pkg.sv =====
package gmbrt_pkg;

    // grid geometry
    localparam int MAX_SIDE = 64;
    localparam int SIDE_W   = 6;
    localparam int CELLS    = 4096;
    localparam int IDX_W    = 12;
    localparam int DIST_W   = 13;
    localparam int PTR_W    = 13;

    localparam logic [DIST_W-1:0] NOT_REACHED = 13'h1000;

    // item functions
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_COMPUTE = 2'd1;
    localparam logic [1:0] FUNC_MOVE    = 2'd2;

    // move codes
    localparam logic [2:0] MOVE_N     = 3'd0;
    localparam logic [2:0] MOVE_E     = 3'd1;
    localparam logic [2:0] MOVE_FWD   = 3'd2;
    localparam logic [2:0] MOVE_RIGHT = 3'd3;
    localparam logic [2:0] MOVE_LEFT  = 3'd4;
    localparam logic [2:0] MOVE_NONE  = 3'd5;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_UNREACH  = 2'd1;
    localparam logic [1:0] STAT_NO_MATCH = 2'd2;
    localparam logic [1:0] STAT_FINISHED = 2'd3;

    // headings
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // register map
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR_PASS,
        OP_LATCH,
        OP_LOAD,
        OP_CLR_DIST,
        OP_BFS_INIT,
        OP_POP,
        OP_VRD,
        OP_VLAT,
        OP_BRD,
        OP_BCHK,
        OP_FRD,
        OP_FIN,
        OP_MBEGIN,
        OP_MRD,
        OP_MCHK,
        OP_PUB
    } op_t;

    // datapath status
    typedef struct packed {
        logic [1:0] func;
        logic       cnt_last;
        logic       q_empty;
        logic       dir_last;
        logic       unreach;
        logic       rem_zero;
        logic       match;
        logic       try_last;
    } dp_stat_t;

endpackage

// ===== src/gmbrt_ram.sv =====
module gmbrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/gmbrt_dp.sv =====
module gmbrt_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  gmbrt_pkg::op_t      op,
    output gmbrt_pkg::dp_stat_t stat,
    input  logic [1:0]          s_func,
    input  logic [6:0]          s_row,
    input  logic [6:0]          s_col,
    input  logic                s_open_right,
    input  logic                s_open_down,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic [2:0]          m_move,
    output logic                m_last,
    output logic [11:0]         m_path_length,
    output logic [1:0]          m_status
);

    localparam int SW = gmbrt_pkg::SIDE_W;
    localparam int IW = gmbrt_pkg::IDX_W;
    localparam int DW = gmbrt_pkg::DIST_W;
    localparam int PW = gmbrt_pkg::PTR_W;

    // configuration and latched item
    logic [6:0]    rows_reg, cols_reg, rows_act, cols_act;
    logic [1:0]    func_reg;
    logic [6:0]    row_reg, col_reg;
    logic          orr_reg, od_reg;

    // sweep counter and queue pointers
    logic [IW-1:0] cnt_reg;
    logic [PW-1:0] head_reg, tail_reg;

    // bfs and walk state
    logic [IW-1:0] v_reg;
    logic [DW-1:0] vdist_reg;
    logic [1:0]    dir_reg;
    logic [SW-1:0] cur_r_reg, cur_c_reg;
    logic [1:0]    heading_reg;
    logic [DW-1:0] remaining_reg;
    logic          unreach_reg, started_reg;
    logic [11:0]   plen_reg;
    logic [1:0]    try_reg;

    // neighbor lookup registers
    logic          nb_ok_reg;
    logic [SW-1:0] w_r_reg, w_c_reg;

    // pending result
    logic [2:0]    res_move_reg;
    logic          res_last_reg;
    logic [1:0]    res_status_reg;

    // ram ports
    logic          pass_we, dist_we, q_we;
    logic [IW-1:0] pass_waddr, dist_waddr, q_waddr;
    logic [IW-1:0] pass_raddr, dist_raddr, q_raddr;
    logic [1:0]    pass_wdata, pass_q;
    logic [DW-1:0] dist_wdata, dist_q;
    logic [IW-1:0] q_wdata, q_q;

    // clamped grid size
    always_comb begin
        rows_act = (rows_reg == 7'd0) ? 7'd1 :
                   (rows_reg > 7'(gmbrt_pkg::MAX_SIDE)) ? 7'(gmbrt_pkg::MAX_SIDE) : rows_reg;
        cols_act = (cols_reg == 7'd0) ? 7'd1 :
                   (cols_reg > 7'(gmbrt_pkg::MAX_SIDE)) ? 7'(gmbrt_pkg::MAX_SIDE) : cols_reg;
    end

    // candidate heading for the walk
    logic [1:0] cand_dir;
    logic [2:0] cand_code;
    logic       try_last;
    always_comb begin
        if (started_reg) begin
            unique case (try_reg)
                2'd0:    cand_dir = heading_reg;
                2'd1:    cand_dir = heading_reg + 2'd1;
                default: cand_dir = heading_reg + 2'd3;
            endcase
            cand_code = gmbrt_pkg::MOVE_FWD + 3'(try_reg);
            try_last  = (try_reg == 2'd2);
        end else begin
            cand_dir  = try_reg[0] ? gmbrt_pkg::DIR_E : gmbrt_pkg::DIR_N;
            cand_code = gmbrt_pkg::MOVE_N + 3'(try_reg[0]);
            try_last  = (try_reg == 2'd1);
        end
    end

    // neighbor of the current cell in the chosen direction
    logic          walk;
    logic [1:0]    nd;
    logic [SW-1:0] br, bc;
    logic [7:0]    nr1, nc1;
    logic          nb_ok;
    logic [SW-1:0] nw_r, nw_c;
    always_comb begin
        walk = (op == gmbrt_pkg::OP_MRD) || (op == gmbrt_pkg::OP_MCHK);
        nd   = walk ? cand_dir : dir_reg;
        br   = walk ? cur_r_reg : v_reg[IW-1:SW];
        bc   = walk ? cur_c_reg : v_reg[SW-1:0];
        nr1  = {2'b0, br} + 8'd1;
        nc1  = {2'b0, bc} + 8'd1;
        unique case (nd)
            gmbrt_pkg::DIR_N: nr1 = {2'b0, br};
            gmbrt_pkg::DIR_S: nr1 = {2'b0, br} + 8'd2;
            gmbrt_pkg::DIR_E: nc1 = {2'b0, bc} + 8'd2;
            default:          nc1 = {2'b0, bc};
        endcase
        nb_ok = (nr1 != 8'd0) && (nc1 != 8'd0) &&
                (nr1 <= {1'b0, rows_act}) && (nc1 <= {1'b0, cols_act});
        nw_r  = SW'(nr1 - 8'd1);
        nw_c  = SW'(nc1 - 8'd1);
    end

    // passage bit and distance test on the read data
    logic pass_bit, b_push, m_match;
    always_comb begin
        pass_bit = (nd == gmbrt_pkg::DIR_N || nd == gmbrt_pkg::DIR_S) ? pass_q[1] : pass_q[0];
        b_push   = nb_ok_reg && pass_bit && (dist_q == gmbrt_pkg::NOT_REACHED);
        m_match  = nb_ok_reg && pass_bit && (dist_q == remaining_reg - DW'(1));
    end

    // load decode
    logic          ld_ok;
    logic [IW-1:0] ld_idx;
    always_comb begin
        ld_ok  = (row_reg != 7'd0) && (col_reg != 7'd0) &&
                 (row_reg <= 7'(gmbrt_pkg::MAX_SIDE)) && (col_reg <= 7'(gmbrt_pkg::MAX_SIDE));
        ld_idx = {SW'(row_reg - 7'd1), SW'(col_reg - 7'd1)};
    end

    // ram port steering
    logic [IW-1:0] tgt_idx, start_idx, w_idx;
    always_comb begin
        tgt_idx    = {SW'(0), SW'(cols_act - 7'd1)};
        start_idx  = {SW'(rows_act - 7'd1), SW'(0)};
        w_idx      = {w_r_reg, w_c_reg};
        pass_we    = 1'b0;
        pass_waddr = cnt_reg;
        pass_wdata = 2'b00;
        dist_we    = 1'b0;
        dist_waddr = cnt_reg;
        dist_wdata = gmbrt_pkg::NOT_REACHED;
        q_we       = 1'b0;
        q_waddr    = tail_reg[IW-1:0];
        q_wdata    = w_idx;
        pass_raddr = (nd == gmbrt_pkg::DIR_N || nd == gmbrt_pkg::DIR_W) ?
                     {nw_r, nw_c} : {br, bc};
        dist_raddr = {nw_r, nw_c};
        q_raddr    = head_reg[IW-1:0];
        unique case (op)
            gmbrt_pkg::OP_CLR_PASS: pass_we = 1'b1;
            gmbrt_pkg::OP_LOAD: begin
                pass_we    = ld_ok;
                pass_waddr = ld_idx;
                pass_wdata = {od_reg && (row_reg != 7'(gmbrt_pkg::MAX_SIDE)),
                              orr_reg && (col_reg != 7'(gmbrt_pkg::MAX_SIDE))};
            end
            gmbrt_pkg::OP_CLR_DIST: dist_we = 1'b1;
            gmbrt_pkg::OP_BFS_INIT: begin
                dist_we    = 1'b1;
                dist_waddr = tgt_idx;
                dist_wdata = '0;
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = tgt_idx;
            end
            gmbrt_pkg::OP_VRD: dist_raddr = q_q;
            gmbrt_pkg::OP_BCHK: begin
                dist_we    = b_push;
                dist_waddr = w_idx;
                dist_wdata = vdist_reg + DW'(1);
                q_we       = b_push;
            end
            gmbrt_pkg::OP_FRD: dist_raddr = start_idx;
            default: ;
        endcase
    end

    gmbrt_ram #(.WIDTH(2), .DEPTH(gmbrt_pkg::CELLS)) u_pass (
        .aclk(aclk), .we(pass_we), .waddr(pass_waddr), .wdata(pass_wdata),
        .raddr(pass_raddr), .rdata(pass_q)
    );

    gmbrt_ram #(.WIDTH(DW), .DEPTH(gmbrt_pkg::CELLS)) u_dist (
        .aclk(aclk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
        .raddr(dist_raddr), .rdata(dist_q)
    );

    gmbrt_ram #(.WIDTH(IW), .DEPTH(gmbrt_pkg::CELLS)) u_queue (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_q)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 7'd1;
            cols_reg <= 7'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == gmbrt_pkg::REG_ROWS) begin
                rows_reg <= pwdata[6:0];
            end else begin
                cols_reg <= pwdata[6:0];
            end
        end
    end

    assign prdata = {25'd0, (paddr[2] == gmbrt_pkg::REG_COLS) ? cols_reg : rows_reg};

    // control state of the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cur_r_reg     <= '0;
            cur_c_reg     <= '0;
            heading_reg   <= gmbrt_pkg::DIR_N;
            remaining_reg <= '0;
            unreach_reg   <= 1'b0;
            started_reg   <= 1'b0;
            plen_reg      <= '0;
            try_reg       <= '0;
            dir_reg       <= '0;
        end else begin
            unique case (op)
                gmbrt_pkg::OP_CLR_PASS, gmbrt_pkg::OP_CLR_DIST: cnt_reg <= cnt_reg + IW'(1);
                gmbrt_pkg::OP_LATCH: begin
                    cnt_reg <= '0;
                    try_reg <= '0;
                end
                gmbrt_pkg::OP_BFS_INIT: begin
                    head_reg <= '0;
                    tail_reg <= PW'(1);
                end
                gmbrt_pkg::OP_POP:  head_reg <= head_reg + PW'(1);
                gmbrt_pkg::OP_VLAT: dir_reg  <= '0;
                gmbrt_pkg::OP_BCHK: begin
                    dir_reg <= dir_reg + 2'd1;
                    if (b_push) begin
                        tail_reg <= tail_reg + PW'(1);
                    end
                end
                gmbrt_pkg::OP_FIN: begin
                    cur_r_reg   <= SW'(rows_act - 7'd1);
                    cur_c_reg   <= '0;
                    heading_reg <= gmbrt_pkg::DIR_N;
                    started_reg <= 1'b0;
                    if (dist_q[DW-1]) begin
                        unreach_reg   <= 1'b1;
                        remaining_reg <= '0;
                        plen_reg      <= '0;
                    end else begin
                        unreach_reg   <= 1'b0;
                        remaining_reg <= dist_q;
                        plen_reg      <= dist_q[11:0];
                    end
                end
                gmbrt_pkg::OP_MCHK: begin
                    if (m_match) begin
                        heading_reg   <= cand_dir;
                        cur_r_reg     <= w_r_reg;
                        cur_c_reg     <= w_c_reg;
                        remaining_reg <= remaining_reg - DW'(1);
                        started_reg   <= 1'b1;
                    end else begin
                        try_reg <= try_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        unique case (op)
            gmbrt_pkg::OP_LATCH: begin
                func_reg       <= s_func;
                row_reg        <= s_row;
                col_reg        <= s_col;
                orr_reg        <= s_open_right;
                od_reg         <= s_open_down;
                res_move_reg   <= gmbrt_pkg::MOVE_NONE;
                res_last_reg   <= 1'b0;
                res_status_reg <= gmbrt_pkg::STAT_OK;
            end
            gmbrt_pkg::OP_VRD:  v_reg     <= q_q;
            gmbrt_pkg::OP_VLAT: vdist_reg <= dist_q;
            gmbrt_pkg::OP_BRD, gmbrt_pkg::OP_MRD: begin
                nb_ok_reg <= nb_ok;
                w_r_reg   <= nw_r;
                w_c_reg   <= nw_c;
            end
            gmbrt_pkg::OP_FIN: begin
                if (dist_q[DW-1]) begin
                    res_status_reg <= gmbrt_pkg::STAT_UNREACH;
                end
            end
            gmbrt_pkg::OP_MBEGIN: begin
                if (unreach_reg) begin
                    res_status_reg <= gmbrt_pkg::STAT_UNREACH;
                end else if (remaining_reg == '0) begin
                    res_status_reg <= gmbrt_pkg::STAT_FINISHED;
                end
            end
            gmbrt_pkg::OP_MCHK: begin
                if (m_match) begin
                    res_move_reg <= cand_code;
                    res_last_reg <= (remaining_reg == DW'(1));
                end else if (try_last) begin
                    res_status_reg <= gmbrt_pkg::STAT_NO_MATCH;
                end
            end
            gmbrt_pkg::OP_PUB: begin
                m_move        <= res_move_reg;
                m_last        <= res_last_reg;
                m_path_length <= plen_reg;
                m_status      <= res_status_reg;
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb begin
        stat.func     = func_reg;
        stat.cnt_last = &cnt_reg;
        stat.q_empty  = (head_reg == tail_reg);
        stat.dir_last = (dir_reg == 2'd3);
        stat.unreach  = unreach_reg;
        stat.rem_zero = (remaining_reg == '0);
        stat.match    = m_match;
        stat.try_last = try_last;
    end

`ifndef SYNTH
    // queue read pointer never passes the write pointer
    a_head_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg) else $error("queue head passed tail");

    // every cell enters the queue at most once
    a_tail_max: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg <= PW'(gmbrt_pkg::CELLS)) else $error("queue overrun");

    // a taken step shortens the remaining path by one
    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == gmbrt_pkg::OP_MCHK && m_match) |=>
        remaining_reg == $past(remaining_reg) - DW'(1)) else $error("bad step count");
`endif

endmodule

// ===== src/gmbrt_ctrl.sv =====
module gmbrt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  gmbrt_pkg::dp_stat_t stat,
    output gmbrt_pkg::op_t      op,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready
);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_DISPATCH, ST_LOAD, ST_CDIST, ST_INIT, ST_POP, ST_VRD,
        ST_VLAT, ST_BRD, ST_BCHK, ST_FRD, ST_FIN, ST_MBEGIN, ST_MRD, ST_MCHK
    } state_t;

    typedef enum logic { PH_WORK, PH_DONE } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg;
    logic   m_valid_reg;
    logic   pub;

    assign s_ready = (state_reg == ST_IDLE) && (phase_reg == PH_WORK);
    assign m_valid = m_valid_reg;
    assign pub     = (phase_reg == PH_DONE) && (!m_valid_reg || m_ready);

    // command and next state
    always_comb begin
        op         = gmbrt_pkg::OP_NONE;
        state_next = state_reg;
        if (phase_reg == PH_DONE) begin
            op = pub ? gmbrt_pkg::OP_PUB : gmbrt_pkg::OP_NONE;
        end else begin
            unique case (state_reg)
                ST_CLR: begin
                    op = gmbrt_pkg::OP_CLR_PASS;
                    if (stat.cnt_last) state_next = ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        op         = gmbrt_pkg::OP_LATCH;
                        state_next = ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    unique case (stat.func)
                        gmbrt_pkg::FUNC_LOAD:    state_next = ST_LOAD;
                        gmbrt_pkg::FUNC_COMPUTE: state_next = ST_CDIST;
                        gmbrt_pkg::FUNC_MOVE:    state_next = ST_MBEGIN;
                        default:                 state_next = ST_IDLE;
                    endcase
                end
                ST_LOAD: begin
                    op         = gmbrt_pkg::OP_LOAD;
                    state_next = ST_IDLE;
                end
                ST_CDIST: begin
                    op = gmbrt_pkg::OP_CLR_DIST;
                    if (stat.cnt_last) state_next = ST_INIT;
                end
                ST_INIT: begin
                    op         = gmbrt_pkg::OP_BFS_INIT;
                    state_next = ST_POP;
                end
                ST_POP: begin
                    if (stat.q_empty) begin
                        state_next = ST_FRD;
                    end else begin
                        op         = gmbrt_pkg::OP_POP;
                        state_next = ST_VRD;
                    end
                end
                ST_VRD: begin
                    op         = gmbrt_pkg::OP_VRD;
                    state_next = ST_VLAT;
                end
                ST_VLAT: begin
                    op         = gmbrt_pkg::OP_VLAT;
                    state_next = ST_BRD;
                end
                ST_BRD: begin
                    op         = gmbrt_pkg::OP_BRD;
                    state_next = ST_BCHK;
                end
                ST_BCHK: begin
                    op         = gmbrt_pkg::OP_BCHK;
                    state_next = stat.dir_last ? ST_POP : ST_BRD;
                end
                ST_FRD: begin
                    op         = gmbrt_pkg::OP_FRD;
                    state_next = ST_FIN;
                end
                ST_FIN: begin
                    op         = gmbrt_pkg::OP_FIN;
                    state_next = ST_IDLE;
                end
                ST_MBEGIN: begin
                    op         = gmbrt_pkg::OP_MBEGIN;
                    state_next = (stat.unreach || stat.rem_zero) ? ST_IDLE : ST_MRD;
                end
                ST_MRD: begin
                    op         = gmbrt_pkg::OP_MRD;
                    state_next = ST_MCHK;
                end
                ST_MCHK: begin
                    op         = gmbrt_pkg::OP_MCHK;
                    state_next = (stat.match || stat.try_last) ? ST_IDLE : ST_MRD;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // state, phase and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            phase_reg   <= PH_WORK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (phase_reg == PH_DONE) begin
                if (pub) phase_reg <= PH_WORK;
            end else if (state_reg != ST_CLR && state_reg != ST_IDLE &&
                         state_next == ST_IDLE) begin
                phase_reg <= PH_DONE;
            end
            if (pub) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    // one item at a time: an accepted word closes the input
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("second word taken");

    // a result is only published while a finished item waits
    a_pub: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == gmbrt_pkg::OP_PUB) |-> (phase_reg == PH_DONE && state_reg == ST_IDLE))
        else $error("publish outside done phase");

    // no input is taken during the reset clearing pass
    a_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_ready) else $error("ready during clear");
`endif

endmodule

// ===== src/grid_maze_bfs_route_tracer_top.sv =====
// channel | ports                                           | handshake
// --------+-------------------------------------------------+-------------------
// input   | s_func s_row s_col s_open_right s_open_down     | s_valid / s_ready
// result  | m_move m_last m_path_length m_status            | m_valid / m_ready
// config  | psel penable pwrite paddr pwdata prdata         | pready tied high
//
// one word at a time
// compute: distance clear over all 4096 cells, then a sweep from the target;
// the single read port on the distance and passage memories paces the sweep
// after reset the whole passage memory is cleared; s_ready stays low
// a result waits in the output register; the next word is taken meanwhile,
// and its result is held back until m_ready frees that register
module grid_maze_bfs_route_tracer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [6:0]  s_row,
    input  logic [6:0]  s_col,
    input  logic        s_open_right,
    input  logic        s_open_down,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_move,
    output logic        m_last,
    output logic [11:0] m_path_length,
    output logic [1:0]  m_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gmbrt_pkg::op_t      op;
    gmbrt_pkg::dp_stat_t stat;

    assign pready = 1'b1;

    // sequencer
    gmbrt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .stat(stat), .op(op),
        .s_valid(s_valid), .s_ready(s_ready), .m_valid(m_valid), .m_ready(m_ready)
    );

    // memories, walk registers and config
    gmbrt_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .op(op), .stat(stat),
        .s_func(s_func), .s_row(s_row), .s_col(s_col),
        .s_open_right(s_open_right), .s_open_down(s_open_down),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata),
        .m_move(m_move), .m_last(m_last), .m_path_length(m_path_length),
        .m_status(m_status)
    );

endmodule
